// ===== hdl/rsa_se_pkg.sv =====
package rsa_se_pkg;

	// fixed field and register widths at the ports
	localparam int FIELD_W   = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t REG_MODULUS          = 2'd0;
	localparam cfg_idx_t REG_PUBLIC_EXPONENT  = 2'd1;
	localparam cfg_idx_t REG_PRIVATE_EXPONENT = 2'd2;

	// request actions
	localparam logic ACT_SIGN   = 1'b0;
	localparam logic ACT_VERIFY = 1'b1;

endpackage

// ===== hdl/rsa_se_if.sv =====
interface rsa_se_req_if;
	logic                            valid;
	logic                            ready;
	logic                            action;
	logic [rsa_se_pkg::FIELD_W-1:0]  operand;
	logic [rsa_se_pkg::FIELD_W-1:0]  expected_message;

	modport source (output valid, action, operand, expected_message, input ready);
	modport sink   (input valid, action, operand, expected_message, output ready);
endinterface

interface rsa_se_res_if;
	logic                            valid;
	logic                            ready;
	logic [rsa_se_pkg::FIELD_W-1:0]  value;
	logic                            valid_res;

	modport source (output valid, value, valid_res, input ready);
	modport sink   (input valid, value, valid_res, output ready);
endinterface

// ===== hdl/rsa_se_modmul.sv =====
module rsa_se_modmul #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] x,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] result
);

	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     r_q;
	logic [W-1:0]     a_q;
	logic [W-1:0]     x_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             phase_q;
	logic             done_q;

	logic [W-1:0]     addend;
	logic [W:0]       sum;
	logic [W+1:0]     diff;
	logic [W-1:0]     r_next;
	logic             last;

	// phase 0 doubles r, phase 1 adds a when the current multiplier bit is set
	assign addend = phase_q ? (x_q[W-1] ? a_q : '0) : r_q;
	assign sum    = {1'b0, r_q} + {1'b0, addend};
	assign diff   = {1'b0, sum} - {2'b0, m};
	assign r_next = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
	assign last   = busy_q && phase_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= last;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_W'(W-1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q - 1'b1;
				end
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= a;
			x_q <= x;
		end else if (busy_q) begin
			r_q <= r_next;
			if (phase_q) begin
				x_q <= x_q << 1;
			end
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

// ===== hdl/rsa_sign_verify_engine.sv =====
// sequence: the base is first reduced mod the modulus, then each exponent bit takes up to two
//   modular products, a multiply when the bit is set and a squaring unless no set bit is left
// throughput: one request at a time, set by the single shift-add modular multiplier
// a zero modulus offers its result in the cycle after the transfer
// reset (arst_n low, asynchronous) sets modulus and both exponents to 1 and empties the engine
module rsa_sign_verify_engine #(
	parameter int OPERAND_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  rsa_se_pkg::cfg_idx_t          cfg_index,
	input  logic [rsa_se_pkg::CFG_W-1:0]  cfg_data,
	rsa_se_req_if.sink                    req,
	rsa_se_res_if.source                  res
);

	localparam int W = OPERAND_BITS;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;
	localparam logic [2:0] ST_STEP   = 3'd2;
	localparam logic [2:0] ST_ACC    = 3'd3;
	localparam logic [2:0] ST_SQ     = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	// configuration registers, held at the operand width
	logic [W-1:0] modulus_q;
	logic [W-1:0] pub_exp_q;
	logic [W-1:0] priv_exp_q;

	// request context
	logic [2:0]   state_q;
	logic         act_q;
	logic [W-1:0] base_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] exp_q;
	logic [W-1:0] expect_q;

	// result registers
	logic [rsa_se_pkg::FIELD_W-1:0] value_q;
	logic                           ok_q;

	// multiplier command
	logic         mm_start_q;
	logic [W-1:0] op_a_q;
	logic [W-1:0] op_x_q;
	logic         mm_done;
	logic [W-1:0] mm_result;

	logic         req_xfer;
	logic         res_xfer;
	logic [W-1:0] one_red;

	assign req_xfer = req.valid && req.ready;
	assign res_xfer = res.valid && res.ready;

	// 1 mod n: zero when n is one, so the base reduction a=1 stays below the modulus
	assign one_red = (modulus_q == W'(1)) ? '0 : W'(1);

	// configuration writes, out-of-range index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= W'(1);
			pub_exp_q  <= W'(1);
			priv_exp_q <= W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				rsa_se_pkg::REG_MODULUS:          modulus_q  <= cfg_data[W-1:0];
				rsa_se_pkg::REG_PUBLIC_EXPONENT:  pub_exp_q  <= cfg_data[W-1:0];
				rsa_se_pkg::REG_PRIVATE_EXPONENT: priv_exp_q <= cfg_data[W-1:0];
				default: ;
			endcase
		end
	end

	// control: state and multiplier start pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mm_start_q <= 1'b0;
		end else begin
			mm_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						if (modulus_q == '0) begin
							// no meaningful reduction, answer zero at once
							state_q <= ST_OUT;
						end else begin
							mm_start_q <= 1'b1;
							state_q    <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (mm_done) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (exp_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						mm_start_q <= 1'b1;
						state_q    <= exp_q[0] ? ST_ACC : ST_SQ;
					end
				end
				ST_ACC: begin
					if (mm_done) begin
						// last set bit: skip the squaring nobody will use
						if (exp_q[W-1:1] == '0) begin
							state_q <= ST_STEP;
						end else begin
							mm_start_q <= 1'b1;
							state_q    <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					if (mm_done) begin
						state_q <= ST_STEP;
					end
				end
				ST_OUT: begin
					if (res_xfer) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					act_q    <= req.action;
					exp_q    <= (req.action == rsa_se_pkg::ACT_VERIFY) ? pub_exp_q : priv_exp_q;
					expect_q <= req.expected_message[W-1:0];
					acc_q    <= W'(1);
					value_q  <= '0;
					ok_q     <= 1'b0;
					// base reduction as (1 mod n) * operand
					op_a_q   <= one_red;
					op_x_q   <= req.operand[W-1:0];
				end
			end
			ST_REDUCE: begin
				if (mm_done) begin
					base_q <= mm_result;
				end
			end
			ST_STEP: begin
				if (exp_q == '0) begin
					value_q <= rsa_se_pkg::FIELD_W'(acc_q);
					ok_q    <= (act_q == rsa_se_pkg::ACT_VERIFY) && (acc_q == expect_q);
				end else if (exp_q[0]) begin
					// base is reduced, so it goes on the addend side
					op_a_q <= base_q;
					op_x_q <= acc_q;
				end else begin
					op_a_q <= base_q;
					op_x_q <= base_q;
				end
			end
			ST_ACC: begin
				if (mm_done) begin
					acc_q <= mm_result;
					if (exp_q[W-1:1] == '0) begin
						exp_q <= exp_q >> 1;
					end else begin
						op_a_q <= base_q;
						op_x_q <= base_q;
					end
				end
			end
			ST_SQ: begin
				if (mm_done) begin
					base_q <= mm_result;
					exp_q  <= exp_q >> 1;
				end
			end
			default: ;
		endcase
	end

	rsa_se_modmul #(
		.W (W)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start_q),
		.a      (op_a_q),
		.x      (op_x_q),
		.m      (modulus_q),
		.done   (mm_done),
		.result (mm_result)
	);

	assign req.ready     = (state_q == ST_IDLE);
	assign res.valid     = (state_q == ST_OUT);
	assign res.value     = value_q;
	assign res.valid_res = ok_q;

	// a request is never taken while a result is still offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && res.valid))
		else $error("request taken while result pending");

	// multiplier only finishes while the sequencer waits on it
	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_REDUCE || state_q == ST_ACC || state_q == ST_SQ))
		else $error("multiplier done outside a product state");

	// a zero modulus short-cuts straight to the result
	a_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && modulus_q == '0) |=> (res.valid && res.value == '0 && !res.valid_res))
		else $error("zero modulus not answered directly");

	// a sign result never reports a match
	a_sign_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.valid_res) |-> (act_q == rsa_se_pkg::ACT_VERIFY))
		else $error("match flagged on sign request");

	// every exponent step either finishes or starts a product
	a_step_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && exp_q != '0) |=> mm_start_q)
		else $error("exponent step without product");

endmodule

// ===== bench/rsa_sign_verify_engine_checker.sv =====
`timescale 1ns / 1ps

module rsa_sign_verify_engine_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  rsa_se_pkg::cfg_idx_t          cfg_index,
	input  logic [rsa_se_pkg::CFG_W-1:0]  cfg_data,
	rsa_se_req_if                         req,
	rsa_se_res_if                         res,
	output int                            mismatch_count,
	output int                            open_answers
);

	typedef struct packed {
		logic [rsa_se_pkg::FIELD_W-1:0] value;
		logic                           valid_res;
	} answer_t;

	logic [rsa_se_pkg::CFG_W-1:0] modulus_r;
	logic [rsa_se_pkg::CFG_W-1:0] pub_exp_r;
	logic [rsa_se_pkg::CFG_W-1:0] priv_exp_r;
	answer_t                      awaited_answers[$];

	// right-to-left square and multiply, products held in 64 bits
	function automatic logic [rsa_se_pkg::FIELD_W-1:0] modexp(
		input logic [rsa_se_pkg::FIELD_W-1:0] base,
		input logic [rsa_se_pkg::CFG_W-1:0] exponent, input logic [rsa_se_pkg::CFG_W-1:0] m);
		logic [63:0]                  acc;
		logic [63:0]                  sq;
		logic [63:0]                  m64;
		logic [rsa_se_pkg::CFG_W-1:0] bits;
		m64  = {32'd0, m};
		acc  = 64'd1;
		sq   = {32'd0, base} % m64;
		bits = exponent;
		while (bits != 0) begin
			if (bits[0]) begin
				acc = (acc * sq) % m64;
			end
			bits = bits >> 1;
			sq   = (sq * sq) % m64;
		end
		return acc[rsa_se_pkg::FIELD_W-1:0];
	endfunction

	function automatic answer_t engine_answer(input logic act,
		input logic [rsa_se_pkg::FIELD_W-1:0] opnd, input logic [rsa_se_pkg::FIELD_W-1:0] msg);
		answer_t ans;
		ans = '0;
		// zero modulus gives zero and no match for either action
		if (modulus_r != 0) begin
			if (act == rsa_se_pkg::ACT_SIGN) begin
				ans.value = modexp(opnd, priv_exp_r, modulus_r);
			end else begin
				ans.value     = modexp(opnd, pub_exp_r, modulus_r);
				ans.valid_res = (ans.value == msg);
			end
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			modulus_r  <= 32'd1;
			pub_exp_r  <= 32'd1;
			priv_exp_r <= 32'd1;
			awaited_answers.delete();
			mismatch_count = 0;
			open_answers   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rsa_se_pkg::REG_MODULUS:          modulus_r  <= cfg_data;
					rsa_se_pkg::REG_PUBLIC_EXPONENT:  pub_exp_r  <= cfg_data;
					rsa_se_pkg::REG_PRIVATE_EXPONENT: priv_exp_r <= cfg_data;
					default: ;
				endcase
			end
			// results first, so a stray result never meets a same-edge expectation
			if (res.valid && res.ready) begin
				if (awaited_answers.size() == 0) begin
					$error("unexpected result transfer: value %h valid_res %b",
						res.value, res.valid_res);
					mismatch_count++;
				end else begin
					want = awaited_answers.pop_front();
					if (res.value !== want.value) begin
						$error("value: expected %h, actual %h", want.value, res.value);
						mismatch_count++;
					end
					if (res.valid_res !== want.valid_res) begin
						$error("valid_res: expected %b, actual %b", want.valid_res,
							res.valid_res);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				awaited_answers.push_back(engine_answer(req.action, req.operand,
					req.expected_message));
			end
			open_answers = awaited_answers.size();
		end
	end

endmodule

// ===== bench/rsa_sign_verify_engine_tb.sv =====
`timescale 1ns / 1ps

module rsa_sign_verify_engine_tb;

	// index 3 decodes to no register, writes there must be dropped
	localparam rsa_se_pkg::cfg_idx_t REG_SPARE = 2'd3;

	// timeout well above the slowest legal run (~140 requests)
	localparam int CYCLE_LIMIT  = 4_000_000;
	// one full exponentiation worth of quiet time after the last result
	localparam int DRAIN_CYCLES = 4400;
	localparam int PER_KEY      = 20;

	// textbook key pair, public and private exponents are inverses mod lambda(n)
	localparam logic [rsa_se_pkg::CFG_W-1:0] KEY_N = 32'd3233;
	localparam logic [rsa_se_pkg::CFG_W-1:0] KEY_E = 32'd17;
	localparam logic [rsa_se_pkg::CFG_W-1:0] KEY_D = 32'd2753;

	typedef struct {
		logic                           act;
		logic [rsa_se_pkg::FIELD_W-1:0] opnd;
		logic [rsa_se_pkg::FIELD_W-1:0] msg;
	} request_t;

	// (input, output) pairs kept from earlier results to build follow-up verifies
	typedef struct {
		logic [rsa_se_pkg::FIELD_W-1:0] input_word;
		logic [rsa_se_pkg::FIELD_W-1:0] output_word;
	} pair_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	rsa_se_pkg::cfg_idx_t         cfg_index;
	logic [rsa_se_pkg::CFG_W-1:0] cfg_data;

	int                           send_idle_pct = 29;
	int                           recv_idle_pct = 88;
	int                           mismatch_count;
	int                           open_answers;
	int                           cycle_count;
	logic [rsa_se_pkg::CFG_W-1:0] cur_modulus = 32'd1;

	request_t         in_flight[$];
	pair_t            signed_pool[$];
	pair_t            echo_pool[$];

	rsa_se_req_if req ();
	rsa_se_res_if res ();

	rsa_sign_verify_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.res       (res)
	);

	rsa_sign_verify_engine_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req            (req),
		.res            (res),
		.mismatch_count (mismatch_count),
		.open_answers   (open_answers)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure, redrawn every cycle
	always @(negedge clk) begin
		res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// pair each result transfer with its request so later verifies can reuse it
	always @(posedge clk) begin
		request_t sent;
		if (arst_n && res.valid && res.ready && in_flight.size() != 0) begin
			sent = in_flight.pop_front();
			if (sent.act == rsa_se_pkg::ACT_SIGN) begin
				signed_pool.push_back('{sent.opnd, res.value});
			end else begin
				echo_pool.push_back('{sent.opnd, res.value});
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// mostly random words, sometimes the edges of the range or of the modulus
	function automatic logic [rsa_se_pkg::FIELD_W-1:0] pick_operand();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return 32'd1;
			2:       return '1;
			3:       return cur_modulus - 32'd1;
			default: return $urandom();
		endcase
	endfunction

	// one request, with random gaps before valid goes high
	task automatic send_request(input logic act, input logic [rsa_se_pkg::FIELD_W-1:0] opnd,
		input logic [rsa_se_pkg::FIELD_W-1:0] msg);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid            <= 1'b1;
		req.action           <= act;
		req.operand          <= opnd;
		req.expected_message <= msg;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		in_flight.push_back('{act, opnd, msg});
		@(negedge clk);
	endtask

	// drop valid and wait until every result has been transferred
	task automatic wait_idle();
		req.valid <= 1'b0;
		while (in_flight.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// registers change only with the engine empty; the spare index gets junk
	task automatic program_regs(input logic [rsa_se_pkg::CFG_W-1:0] n,
		input logic [rsa_se_pkg::CFG_W-1:0] e, input logic [rsa_se_pkg::CFG_W-1:0] d);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= rsa_se_pkg::REG_MODULUS;
		cfg_data  <= n;
		@(negedge clk);
		cfg_index <= rsa_se_pkg::REG_PUBLIC_EXPONENT;
		cfg_data  <= e;
		@(negedge clk);
		cfg_index <= rsa_se_pkg::REG_PRIVATE_EXPONENT;
		cfg_data  <= d;
		@(negedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= $urandom();
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_modulus = n;
		signed_pool.delete();
		echo_pool.delete();
	endtask

	// random mix of signs, sign-then-verify round trips, replays and noise
	task automatic random_requests(input int count);
		repeat (count) begin
			int                             choice;
			int                             slot;
			logic [rsa_se_pkg::FIELD_W-1:0] text;
			choice = $urandom_range(0, 99);
			if (choice < 40) begin
				send_request(rsa_se_pkg::ACT_SIGN, pick_operand(), $urandom());
			end else if (choice < 65 && signed_pool.size() != 0) begin
				// verify a signature against its message, matches under a true key pair
				slot = $urandom_range(0, signed_pool.size() - 1);
				text = signed_pool[slot].input_word;
				if (cur_modulus != 0) begin
					text = text % cur_modulus;
				end
				send_request(rsa_se_pkg::ACT_VERIFY, signed_pool[slot].output_word, text);
			end else if (choice < 80 && echo_pool.size() != 0) begin
				// same operand again, expecting what came back last time
				slot = $urandom_range(0, echo_pool.size() - 1);
				send_request(rsa_se_pkg::ACT_VERIFY, echo_pool[slot].input_word,
					echo_pool[slot].output_word);
			end else if (choice < 90 && echo_pool.size() != 0) begin
				// near miss, one bit of the recovered value flipped
				slot = $urandom_range(0, echo_pool.size() - 1);
				text = echo_pool[slot].output_word ^ (32'd1 << $urandom_range(0, 31));
				send_request(rsa_se_pkg::ACT_VERIFY, echo_pool[slot].input_word, text);
			end else begin
				send_request(rsa_se_pkg::ACT_VERIFY, pick_operand(), $urandom());
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = rsa_se_pkg::REG_MODULUS;
		cfg_data             = '0;
		req.valid            = 1'b0;
		req.action           = rsa_se_pkg::ACT_SIGN;
		req.operand          = '0;
		req.expected_message = '0;
		res.ready            = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: modulus 1, both exponents 1, every value reduces to zero
		send_request(rsa_se_pkg::ACT_SIGN, '0, '0);
		send_request(rsa_se_pkg::ACT_SIGN, '1, '1);
		send_request(rsa_se_pkg::ACT_VERIFY, '1, '0);
		send_request(rsa_se_pkg::ACT_VERIFY, 32'd5, '1);

		// zero exponent returns 1 even with modulus 1
		program_regs(32'd1, '0, '0);
		send_request(rsa_se_pkg::ACT_SIGN, '1, '0);
		send_request(rsa_se_pkg::ACT_VERIFY, '0, 32'd1);
		send_request(rsa_se_pkg::ACT_VERIFY, 32'd7, '0);

		// zero modulus: zero value and no match, whatever the operands
		program_regs('0, 32'd5, 32'd3);
		send_request(rsa_se_pkg::ACT_SIGN, 32'd123, '1);
		send_request(rsa_se_pkg::ACT_VERIFY, '0, '0);
		send_request(rsa_se_pkg::ACT_VERIFY, '1, '1);

		// all-ones modulus and exponents; n-1 is minus one, odd power keeps it
		program_regs('1, '1, '1);
		send_request(rsa_se_pkg::ACT_SIGN, '0, '0);
		send_request(rsa_se_pkg::ACT_SIGN, 32'd1, '0);
		send_request(rsa_se_pkg::ACT_SIGN, 32'hFFFF_FFFE, '0);
		send_request(rsa_se_pkg::ACT_SIGN, '1, '0);
		send_request(rsa_se_pkg::ACT_VERIFY, 32'hFFFF_FFFE, 32'd1);
		send_request(rsa_se_pkg::ACT_VERIFY, 32'hFFFF_FFFE, 32'hFFFF_FFFE);

		// key pair with roles swapped so 65 signs to 2790 and verifies back
		program_regs(KEY_N, KEY_D, KEY_E);
		send_request(rsa_se_pkg::ACT_SIGN, 32'd65, '0);
		send_request(rsa_se_pkg::ACT_VERIFY, 32'd2790, 32'd65);
		send_request(rsa_se_pkg::ACT_SIGN, KEY_N, '0);
		send_request(rsa_se_pkg::ACT_VERIFY, KEY_N - 32'd1, KEY_N - 32'd1);

		// zero public exponent with a wide modulus, 0^0 counts as 1
		program_regs(32'h8000_0001, '0, '1);
		send_request(rsa_se_pkg::ACT_VERIFY, '0, 32'd1);
		send_request(rsa_se_pkg::ACT_SIGN, 32'd2, '0);

		// slow sender against a very slow receiver
		program_regs(KEY_N, KEY_E, KEY_D);
		random_requests(PER_KEY);
		program_regs({1'b1, 31'($urandom())}, $urandom(), $urandom());
		random_requests(PER_KEY);

		// and the other way round
		send_idle_pct = 88;
		recv_idle_pct = 29;
		program_regs(KEY_N, KEY_D, KEY_E);
		random_requests(PER_KEY);
		program_regs($urandom_range(2, 255), $urandom(), $urandom());
		random_requests(PER_KEY);

		// back to back, no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_regs($urandom(), $urandom(), $urandom());
		random_requests(PER_KEY);
		program_regs(KEY_N, KEY_E, KEY_D);
		random_requests(PER_KEY);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && open_answers == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/rsa_se_pkg.sv
hdl/rsa_se_if.sv
hdl/rsa_se_modmul.sv
hdl/rsa_sign_verify_engine.sv
bench/rsa_sign_verify_engine_checker.sv
bench/rsa_sign_verify_engine_tb.sv
